@@ rtl/compass_heading_averager_core_macros.svh @@
// Concurrent assertion helpers; compiled out under SYNTHESIS.
`ifndef COMPASS_HEADING_AVERAGER_CORE_MACROS_SVH
`define COMPASS_HEADING_AVERAGER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CHA_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define CHA_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define CHA_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)
`define CHA_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

@@ rtl/cha_pkg.sv @@
package cha_pkg;

    localparam int XY_W          = 16;
    localparam int SUM_W         = 23;
    localparam int CNT_W         = 8;
    localparam int OUT_W         = 15;
    localparam int DVS_W         = CNT_W + 1;

    localparam int CORDIC_STEPS  = 18;
    localparam int ITER_W        = $clog2(CORDIC_STEPS);
    localparam int ACC_BITS      = 20;
    localparam int PRESCALE      = 16;
    localparam int CX_W          = 36;
    localparam int Z_W           = 28;
    localparam int A_W           = 29;

    localparam int FULL_TURN_DEG    = 360;
    localparam int HALF_TURN_DEG    = 180;
    localparam int QUARTER_TURN_DEG = 90;

    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 3;
    localparam logic [0:0] REG_SAMPLE_COUNT = 1'b0;

    // one classified sample: magnitudes plus quadrant flags
    typedef struct packed {
        logic [XY_W-1:0] ax;
        logic [XY_W-1:0] ay;
        logic            x_neg;
        logic            y_neg;
        logic            is_zero;
    } sample_t;

    // atan(2^-i) in units of 2^-20 degree
    function automatic logic [Z_W-1:0] atan_deg(input logic [ITER_W-1:0] idx);
        logic [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 28'd47185920;
            5'd1:    v = 28'd27855475;
            5'd2:    v = 28'd14718068;
            5'd3:    v = 28'd7471121;
            5'd4:    v = 28'd3750058;
            5'd5:    v = 28'd1876857;
            5'd6:    v = 28'd938658;
            5'd7:    v = 28'd469357;
            5'd8:    v = 28'd234682;
            5'd9:    v = 28'd117342;
            5'd10:   v = 28'd58671;
            5'd11:   v = 28'd29335;
            5'd12:   v = 28'd14668;
            5'd13:   v = 28'd7334;
            5'd14:   v = 28'd3667;
            5'd15:   v = 28'd1833;
            5'd16:   v = 28'd917;
            5'd17:   v = 28'd458;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/cha_queue.sv @@
`include "compass_heading_averager_core_macros.svh"

module cha_queue #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [cha_pkg::XY_W-1:0] x_component,
    input  logic signed [cha_pkg::XY_W-1:0] y_component,
    output logic                          head_valid,
    output cha_pkg::sample_t              head,
    input  logic                          head_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);

    cha_pkg::sample_t        mem [QUEUE_DEPTH];
    cha_pkg::sample_t        entry;
    logic [PTR_W-1:0]        wr_ptr_reg;
    logic [PTR_W-1:0]        rd_ptr_reg;
    logic [QCNT_W-1:0]       count_reg;
    logic                    push;
    logic                    pop;

    // classify: fold into the first quadrant, keep the signs
    always_comb
    begin
        entry.ax      = x_component[cha_pkg::XY_W-1] ? (~x_component + 1'b1) : x_component;
        entry.ay      = y_component[cha_pkg::XY_W-1] ? (~y_component + 1'b1) : y_component;
        entry.x_neg   = x_component[cha_pkg::XY_W-1];
        entry.y_neg   = y_component[cha_pkg::XY_W-1];
        entry.is_zero = (x_component == '0) && (y_component == '0);
    end

    assign in_stall   = (count_reg == FULL_CNT);
    assign push       = in_valid && !in_stall;
    assign head_valid = (count_reg != '0);
    assign pop        = head_pop && head_valid;
    assign head       = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `CHA_ASSERT_IMP(a_empty_ptrs_match, clk, rst_n, count_reg == '0, wr_ptr_reg == rd_ptr_reg)

endmodule

@@ rtl/cha_cordic.sv @@
`include "compass_heading_averager_core_macros.svh"

module cha_cordic #(
    parameter int ANGLE_FRAC_BITS = 6
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           entry_valid,
    input  cha_pkg::sample_t               entry,
    output logic                           entry_pop,
    output logic                           az_valid,
    output logic [cha_pkg::SUM_W-1:0]      az,
    input  logic                           az_ready
);

    localparam int CX_W  = cha_pkg::CX_W;
    localparam int Z_W   = cha_pkg::Z_W;
    localparam int A_W   = cha_pkg::A_W;
    localparam int SUM_W = cha_pkg::SUM_W;
    localparam int ITER_W = cha_pkg::ITER_W;
    localparam int RSH   = cha_pkg::ACC_BITS - ANGLE_FRAC_BITS;
    localparam int PAD_W = CX_W - cha_pkg::XY_W - cha_pkg::PRESCALE;

    localparam logic signed [Z_W-1:0] QUARTER_Z =
        Z_W'(cha_pkg::QUARTER_TURN_DEG) << cha_pkg::ACC_BITS;
    localparam logic [A_W-1:0] QUARTER_A = A_W'(cha_pkg::QUARTER_TURN_DEG) << cha_pkg::ACC_BITS;
    localparam logic [A_W-1:0] HALF_A    = A_W'(cha_pkg::HALF_TURN_DEG) << cha_pkg::ACC_BITS;
    localparam logic [A_W-1:0] FULL_A    = A_W'(cha_pkg::FULL_TURN_DEG) << cha_pkg::ACC_BITS;
    localparam logic [A_W:0]   RND_HALF  = (A_W+1)'(1) << (RSH - 1);
    localparam logic [SUM_W-1:0] WRAP_H  = SUM_W'(cha_pkg::FULL_TURN_DEG) << ANGLE_FRAC_BITS;
    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(cha_pkg::CORDIC_STEPS - 1);

    typedef enum logic [2:0] {
        C_IDLE,
        C_RUN,
        C_MAP,
        C_ROUND,
        C_HOLD
    } cstate_t;

    cstate_t                 state_reg;
    logic signed [CX_W-1:0]  cx_reg;
    logic signed [CX_W-1:0]  cy_reg;
    logic signed [Z_W-1:0]   z_reg;
    logic [ITER_W-1:0]       iter_reg;
    logic                    x_neg_reg;
    logic                    y_neg_reg;
    logic                    zero_reg;
    logic [A_W-1:0]          a_reg;
    logic [SUM_W-1:0]        h_reg;

    logic signed [CX_W-1:0]  dx;
    logic signed [CX_W-1:0]  dy;
    logic signed [CX_W-1:0]  cx_next;
    logic signed [CX_W-1:0]  cy_next;
    logic signed [Z_W-1:0]   z_next;
    logic [A_W-1:0]          zc;
    logic [A_W-1:0]          a_next;
    logic [A_W:0]            rnd;
    logic [SUM_W-1:0]        h_raw;
    logic [SUM_W-1:0]        h_next;

    // one vectoring step; >>> floors like the arithmetic model
    always_comb
    begin
        dx = cy_reg >>> iter_reg;
        dy = cx_reg >>> iter_reg;
        if (!cy_reg[CX_W-1])
        begin
            cx_next = cx_reg + dx;
            cy_next = cy_reg - dy;
            z_next  = z_reg + signed'(cha_pkg::atan_deg(iter_reg));
        end
        else
        begin
            cx_next = cx_reg - dx;
            cy_next = cy_reg + dy;
            z_next  = z_reg - signed'(cha_pkg::atan_deg(iter_reg));
        end
    end

    // clamp to 0..90 and place in the quadrant
    always_comb
    begin
        if (z_reg[Z_W-1])
        begin
            zc = '0;
        end
        else if (z_reg > QUARTER_Z)
        begin
            zc = QUARTER_A;
        end
        else
        begin
            zc = {{(A_W-Z_W){1'b0}}, z_reg};
        end
        case ({x_neg_reg, y_neg_reg})
            2'b00:   a_next = zc;
            2'b01:   a_next = FULL_A - zc;
            2'b10:   a_next = HALF_A - zc;
            default: a_next = HALF_A + zc;
        endcase
    end

    // round half up to the output grid, 360 folds to 0
    always_comb
    begin
        rnd   = {1'b0, a_reg} + RND_HALF;
        h_raw = SUM_W'(rnd >> RSH);
        if (zero_reg)
        begin
            h_next = '0;
        end
        else if (h_raw >= WRAP_H)
        begin
            h_next = h_raw - WRAP_H;
        end
        else
        begin
            h_next = h_raw;
        end
    end

    assign entry_pop = (state_reg == C_IDLE) && entry_valid;
    assign az_valid  = (state_reg == C_HOLD);
    assign az        = h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
        end
        else
        begin
            unique case (state_reg)
                C_IDLE:
                begin
                    if (entry_valid)
                    begin
                        cx_reg    <= signed'({{PAD_W{1'b0}}, entry.ax,
                                              {cha_pkg::PRESCALE{1'b0}}});
                        cy_reg    <= signed'({{PAD_W{1'b0}}, entry.ay,
                                              {cha_pkg::PRESCALE{1'b0}}});
                        z_reg     <= '0;
                        iter_reg  <= '0;
                        x_neg_reg <= entry.x_neg;
                        y_neg_reg <= entry.y_neg;
                        zero_reg  <= entry.is_zero;
                        state_reg <= C_RUN;
                    end
                end
                C_RUN:
                begin
                    cx_reg   <= cx_next;
                    cy_reg   <= cy_next;
                    z_reg    <= z_next;
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == LAST_ITER)
                    begin
                        state_reg <= C_MAP;
                    end
                end
                C_MAP:
                begin
                    a_reg     <= a_next;
                    state_reg <= C_ROUND;
                end
                C_ROUND:
                begin
                    h_reg     <= h_next;
                    state_reg <= C_HOLD;
                end
                C_HOLD:
                begin
                    if (az_ready)
                    begin
                        state_reg <= C_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    `CHA_ASSERT_IMP(a_iter_in_range, clk, rst_n, state_reg == C_RUN, iter_reg <= LAST_ITER)
    `CHA_ASSERT_NXT(a_last_step_maps, clk, rst_n, (state_reg == C_RUN) && (iter_reg == LAST_ITER), state_reg == C_MAP)

endmodule

@@ rtl/cha_accum.sv @@
`include "compass_heading_averager_core_macros.svh"

module cha_accum (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          az_valid,
    input  logic [cha_pkg::SUM_W-1:0]     az,
    output logic                          az_ready,
    input  logic [cha_pkg::CNT_W-1:0]     sample_count,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [cha_pkg::OUT_W-1:0]     average_heading
);

    localparam int SUM_W = cha_pkg::SUM_W;
    localparam int CNT_W = cha_pkg::CNT_W;
    localparam int DVS_W = cha_pkg::DVS_W;
    localparam int DC_W  = $clog2(SUM_W);
    localparam logic [DC_W-1:0] LAST_BIT = DC_W'(SUM_W - 1);
    localparam logic [DVS_W-1:0] FULL_WRAP_DIV = DVS_W'(1) << CNT_W;

    typedef enum logic [1:0] {
        A_IDLE,
        A_DIV,
        A_DONE
    } astate_t;

    astate_t                 state_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [CNT_W-1:0]        seen_reg;
    logic [SUM_W-1:0]        dividend_reg;
    logic [DVS_W-1:0]        divisor_reg;
    logic [DVS_W-1:0]        rem_reg;
    logic [DC_W-1:0]         bit_reg;
    logic                    out_valid_reg;
    logic [cha_pkg::OUT_W-1:0] out_reg;

    logic [SUM_W-1:0]        sum_next;
    logic [CNT_W-1:0]        seen_next;
    logic [CNT_W-1:0]        need;
    logic                    emit;
    logic [DVS_W:0]          trial;
    logic                    ge;
    logic [DVS_W-1:0]        rem_next;
    logic                    out_take;
    logic                    out_free;

    assign az_ready  = (state_reg == A_IDLE);
    assign sum_next  = sum_reg + az;
    assign seen_next = seen_reg + 1'b1;
    assign need      = (sample_count == '0) ? CNT_W'(1) : sample_count;
    // a wrapped count means 256 samples
    assign emit      = (seen_next == '0) || (seen_next >= need);

    // restoring divide, one quotient bit per cycle
    assign trial    = {rem_reg, dividend_reg[SUM_W-1]};
    assign ge       = (trial >= {1'b0, divisor_reg});
    assign rem_next = ge ? DVS_W'(trial - {1'b0, divisor_reg}) : DVS_W'(trial);

    assign out_take = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign out_valid       = out_valid_reg;
    assign average_heading = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= A_IDLE;
            sum_reg       <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a word taken while the next mean loads keeps valid high
            if (out_take && (state_reg != A_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                A_IDLE:
                begin
                    if (az_valid)
                    begin
                        if (emit)
                        begin
                            dividend_reg <= sum_next;
                            divisor_reg  <= (seen_next == '0) ? FULL_WRAP_DIV
                                                              : {1'b0, seen_next};
                            rem_reg      <= '0;
                            bit_reg      <= '0;
                            sum_reg      <= '0;
                            seen_reg     <= '0;
                            state_reg    <= A_DIV;
                        end
                        else
                        begin
                            sum_reg  <= sum_next;
                            seen_reg <= seen_next;
                        end
                    end
                end
                A_DIV:
                begin
                    rem_reg      <= rem_next;
                    dividend_reg <= {dividend_reg[SUM_W-2:0], ge};
                    bit_reg      <= bit_reg + 1'b1;
                    if (bit_reg == LAST_BIT)
                    begin
                        state_reg <= A_DONE;
                    end
                end
                A_DONE:
                begin
                    if (out_free)
                    begin
                        out_reg       <= dividend_reg[cha_pkg::OUT_W-1:0];
                        out_valid_reg <= 1'b1;
                        state_reg     <= A_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    `CHA_ASSERT_IMP(a_rem_below_divisor, clk, rst_n, state_reg == A_DIV, rem_reg < divisor_reg)
    `CHA_ASSERT_IMP(a_out_from_divider, clk, rst_n, $rose(out_valid_reg), $past(state_reg == A_DONE))

endmodule

@@ rtl/compass_heading_averager_core.sv @@
// Compass heading averager. Each word on the input channel is one signed X/Y
// magnetometer sample; the block finds its azimuth (0 to under 360 degrees,
// ANGLE_FRAC_BITS fractional bits, atan2(0,0) = 0) with an 18-iteration CORDIC,
// sums sample_count azimuths and emits their truncated mean as one output word,
// then starts a new group. Angles are averaged as plain numbers, so a group
// straddling north gives a mean near 180. An input queue of QUEUE_DEPTH words
// takes samples while the CORDIC is busy. The CORDIC unit works on one sample
// at a time (load, 18 iterations, quadrant map, rounding, hand-off); a sample
// that closes a group then keeps the accumulator busy for 23 one-bit divide
// steps and the output load, which overlaps the next sample's CORDIC pass. A
// hand-off waits until the accumulator is idle again, which a stalled output
// delays. sample_count sits at byte address 0 of the APB port (reset 1, 0 acts
// as 1) and should be written only while no sample is in flight.
module compass_heading_averager_core #(
    parameter int ANGLE_FRAC_BITS = 6,
    parameter int QUEUE_DEPTH     = 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [cha_pkg::XY_W-1:0]     x_component,
    input  logic signed [cha_pkg::XY_W-1:0]     y_component,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [cha_pkg::OUT_W-1:0]           average_heading,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cha_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [cha_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [cha_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    logic [cha_pkg::CNT_W-1:0]  sample_count_reg;
    logic                       reg_hit;
    cha_pkg::sample_t           head;
    logic                       head_valid;
    logic                       head_pop;
    logic                       az_valid;
    logic                       az_ready;
    logic [cha_pkg::SUM_W-1:0]  az;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[cha_pkg::APB_ADDR_W-1] == cha_pkg::REG_SAMPLE_COUNT);
    assign prdata  = reg_hit ? {{(cha_pkg::APB_DATA_W-cha_pkg::CNT_W){1'b0}}, sample_count_reg}
                             : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= cha_pkg::CNT_W'(1);
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            sample_count_reg <= pwdata[cha_pkg::CNT_W-1:0];
        end
    end

    cha_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .x_component (x_component),
        .y_component (y_component),
        .head_valid  (head_valid),
        .head        (head),
        .head_pop    (head_pop)
    );

    cha_cordic #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_cordic (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (head_valid),
        .entry       (head),
        .entry_pop   (head_pop),
        .az_valid    (az_valid),
        .az          (az),
        .az_ready    (az_ready)
    );

    cha_accum u_accum (
        .clk             (clk),
        .rst_n           (rst_n),
        .az_valid        (az_valid),
        .az              (az),
        .az_ready        (az_ready),
        .sample_count    (sample_count_reg),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .average_heading (average_heading)
    );

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    localparam int XY_W             = cha_pkg::XY_W;
    localparam int CNT_W            = cha_pkg::CNT_W;
    localparam int OUT_W            = cha_pkg::OUT_W;
    localparam int SUM_W            = cha_pkg::SUM_W;
    localparam int APB_ADDR_W       = cha_pkg::APB_ADDR_W;
    localparam int APB_DATA_W       = cha_pkg::APB_DATA_W;
    localparam int CORDIC_STEPS     = cha_pkg::CORDIC_STEPS;
    localparam int ACC_BITS         = cha_pkg::ACC_BITS;
    localparam int PRESCALE         = cha_pkg::PRESCALE;
    localparam int FULL_TURN_DEG    = cha_pkg::FULL_TURN_DEG;
    localparam int HALF_TURN_DEG    = cha_pkg::HALF_TURN_DEG;
    localparam int QUARTER_TURN_DEG = cha_pkg::QUARTER_TURN_DEG;
    localparam logic [0:0] REG_SAMPLE_COUNT = cha_pkg::REG_SAMPLE_COUNT;

    localparam int ANGLE_FRAC   = 6;
    localparam int DRAIN_CYCLES = 160;
    localparam int RANDOM_ITEMS = 1750;
    localparam int TIMEOUT_NS   = 5_000_000;
    localparam logic [APB_ADDR_W-1:0] ADDR_SAMPLE_COUNT =
        APB_ADDR_W'(4 * int'(REG_SAMPLE_COUNT));
    localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED =
        APB_ADDR_W'(4 * (int'(REG_SAMPLE_COUNT) + 1));
    localparam longint SUM_MASK = (64'sd1 <<< SUM_W) - 1;
    localparam longint HEADING_MASK = (64'sd1 <<< OUT_W) - 1;

    // atan(2^-i) in 2^-20 degree
    localparam longint ATAN_STEP [CORDIC_STEPS] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
        938658, 469357, 234682, 117342, 58671, 29335,
        14668, 7334, 3667, 1833, 917, 458
    };

    typedef enum logic [1:0] {ROW_SAMPLE, ROW_SET_COUNT, ROW_SET_UNMAPPED} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic [CNT_W-1:0]       value;
        bit                     typed;
        logic [OUT_W-1:0]       heading;
    } script_row_t;

    localparam int SCRIPT_LEN = 27;
    script_row_t script [SCRIPT_LEN] = '{
        '{ROW_SAMPLE, 0, 0, 0, 1'b1, 0},
        '{ROW_SAMPLE, 32767, 0, 0, 1'b1, 0},
        '{ROW_SAMPLE, 0, 32767, 0, 1'b1, 5760},
        '{ROW_SAMPLE, -32768, 0, 0, 1'b1, 11520},
        '{ROW_SAMPLE, 0, -32768, 0, 1'b1, 17280},
        '{ROW_SAMPLE, 1, 0, 0, 1'b1, 0},
        '{ROW_SAMPLE, 0, 1, 0, 1'b1, 5760},
        '{ROW_SAMPLE, -1, 0, 0, 1'b1, 11520},
        '{ROW_SAMPLE, 0, -1, 0, 1'b1, 17280},
        // a hair under 360 rounds up and wraps to 0
        '{ROW_SAMPLE, 32767, -1, 0, 1'b1, 0},
        '{ROW_SAMPLE, 1, 1, 0, 1'b0, 0},
        '{ROW_SAMPLE, -1, 1, 0, 1'b0, 0},
        '{ROW_SAMPLE, -1, -1, 0, 1'b0, 0},
        '{ROW_SAMPLE, 1, -1, 0, 1'b0, 0},
        '{ROW_SAMPLE, -32768, -32768, 0, 1'b0, 0},
        '{ROW_SAMPLE, 32767, 32767, 0, 1'b0, 0},
        '{ROW_SAMPLE, -32768, 32767, 0, 1'b0, 0},
        '{ROW_SAMPLE, 32767, -32768, 0, 1'b0, 0},
        '{ROW_SET_COUNT, 0, 0, 0, 1'b0, 0},
        '{ROW_SAMPLE, 100, -200, 0, 1'b0, 0},
        '{ROW_SAMPLE, -5000, 3, 0, 1'b0, 0},
        '{ROW_SET_COUNT, 0, 0, 4, 1'b0, 0},
        '{ROW_SAMPLE, 3000, 4000, 0, 1'b0, 0},
        '{ROW_SAMPLE, -12345, 222, 0, 1'b0, 0},
        '{ROW_SAMPLE, 7, -32768, 0, 1'b0, 0},
        '{ROW_SET_UNMAPPED, 0, 0, 9, 1'b0, 0},
        // count dropped below the three already summed: next sample closes
        '{ROW_SET_COUNT, 0, 0, 2, 1'b0, 0}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic signed [XY_W-1:0] x_component;
    logic signed [XY_W-1:0] y_component;
    logic                   out_valid;
    logic                   out_stall;
    logic [OUT_W-1:0]       average_heading;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    logic [OUT_W-1:0] heading_q [$];
    logic [CNT_W-1:0] count_cfg;
    longint           heading_sum;
    int unsigned      samples_seen;
    int               n_errors;
    int               n_sent;
    int               n_checked;
    int               n_settings;
    bit               quiet;

    compass_heading_averager_core u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .x_component     (x_component),
        .y_component     (y_component),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .average_heading (average_heading),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic bit idle_roll();
        return !quiet && ($urandom_range(0, 99) < 11);
    endfunction

    function automatic void log_error(input string msg);
        if (n_errors < 10)
        begin
            $display("%s", msg);
        end
        n_errors++;
    endfunction

    // azimuth of one sample in 2^-ANGLE_FRAC degree, 0 .. under 360
    function automatic longint sample_azimuth(input logic signed [XY_W-1:0] xs,
                                              input logic signed [XY_W-1:0] ys);
        longint cx;
        longint cy;
        longint dx;
        longint dy;
        longint z;
        longint a;
        longint h;
        longint full_turn;
        longint half_turn;
        longint quarter_turn;
        full_turn    = longint'(FULL_TURN_DEG) <<< ACC_BITS;
        half_turn    = longint'(HALF_TURN_DEG) <<< ACC_BITS;
        quarter_turn = longint'(QUARTER_TURN_DEG) <<< ACC_BITS;
        if (xs == 0 && ys == 0)
        begin
            return 0;
        end
        cx = (xs < 0) ? -longint'(xs) : longint'(xs);
        cy = (ys < 0) ? -longint'(ys) : longint'(ys);
        cx = cx <<< PRESCALE;
        cy = cy <<< PRESCALE;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0)
            begin
                cx = cx + dx;
                cy = cy - dy;
                z  = z + ATAN_STEP[i];
            end
            else
            begin
                cx = cx - dx;
                cy = cy + dy;
                z  = z - ATAN_STEP[i];
            end
        end
        if (z < 0)
        begin
            z = 0;
        end
        if (z > quarter_turn)
        begin
            z = quarter_turn;
        end
        if (xs >= 0)
        begin
            a = (ys >= 0) ? z : full_turn - z;
        end
        else
        begin
            a = (ys >= 0) ? half_turn - z : half_turn + z;
        end
        h = (a + (64'sd1 <<< (ACC_BITS - ANGLE_FRAC - 1))) >>> (ACC_BITS - ANGLE_FRAC);
        if (h >= (longint'(FULL_TURN_DEG) <<< ANGLE_FRAC))
        begin
            h = h - (longint'(FULL_TURN_DEG) <<< ANGLE_FRAC);
        end
        return h;
    endfunction

    // fold one accepted sample into the running mean; queue a heading if it closes
    function automatic void fold_sample(input logic signed [XY_W-1:0] xs,
                                        input logic signed [XY_W-1:0] ys,
                                        input bit typed,
                                        input logic [OUT_W-1:0] typed_heading);
        int unsigned need;
        int unsigned divisor;
        longint      mean;
        need         = (count_cfg == 0) ? 1 : count_cfg;
        heading_sum  = (heading_sum + sample_azimuth(xs, ys)) & SUM_MASK;
        samples_seen = (samples_seen + 1) & 8'hFF;
        if (samples_seen == 0 || samples_seen >= need)
        begin
            divisor = (samples_seen == 0) ? 256 : samples_seen;
            mean    = (heading_sum / divisor) & HEADING_MASK;
            heading_q.push_back(typed ? typed_heading : OUT_W'(mean));
            heading_sum  = 0;
            samples_seen = 0;
        end
    endfunction

    task automatic push_sample(input logic signed [XY_W-1:0] xs,
                               input logic signed [XY_W-1:0] ys,
                               input bit typed,
                               input logic [OUT_W-1:0] typed_heading);
        quiet = (n_sent >= 600 && n_sent < 900);
        @(negedge clk);
        while (idle_roll())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        x_component <= xs;
        y_component <= ys;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        fold_sample(xs, ys, typed, typed_heading);
        n_sent++;
    endtask

    task automatic rest_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic apb_access(input logic write_en,
                              input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data,
                              output logic [APB_DATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write_en;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // write only once the block has drained, then read the count back
    task automatic set_register(input logic [APB_ADDR_W-1:0] addr,
                                input logic [CNT_W-1:0] value);
        logic [APB_DATA_W-1:0] rdata;
        rest_input();
        while (heading_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        apb_access(1'b1, addr, APB_DATA_W'(value), rdata);
        if (addr == ADDR_SAMPLE_COUNT)
        begin
            count_cfg = value;
        end
        n_settings++;
        apb_access(1'b0, ADDR_SAMPLE_COUNT, '0, rdata);
        if (rdata != APB_DATA_W'(count_cfg))
        begin
            log_error($sformatf("sample_count readback: expected %0d, got %0d",
                                count_cfg, rdata));
        end
    endtask

    function automatic logic signed [XY_W-1:0] pick_axis();
        case ($urandom_range(0, 9))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2:       return '0;
            3, 4:    return XY_W'($signed($urandom_range(0, 8)) - 4);
            default: return XY_W'($urandom());
        endcase
    endfunction

    always @(negedge clk)
    begin
        out_stall <= idle_roll();
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (heading_q.size() == 0)
            begin
                log_error($sformatf("unexpected heading word %0d", average_heading));
            end
            else
            begin
                if (average_heading !== heading_q[0])
                begin
                    log_error($sformatf("heading mismatch: expected %0d, got %0d",
                                        heading_q[0], average_heading));
                end
                void'(heading_q.pop_front());
                n_checked++;
            end
        end
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

    initial
    begin : main
        int          group_len;
        int          phase_len;
        logic [CNT_W-1:0] cnt;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        x_component = '0;
        y_component = '0;
        out_stall   = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        count_cfg    = 8'd1;
        heading_sum  = 0;
        samples_seen = 0;
        n_errors     = 0;
        n_sent       = 0;
        n_checked    = 0;
        n_settings   = 0;
        quiet        = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            case (script[i].kind)
                ROW_SAMPLE:
                    push_sample(script[i].x, script[i].y, script[i].typed,
                                script[i].heading);
                ROW_SET_COUNT:
                    set_register(ADDR_SAMPLE_COUNT, script[i].value);
                ROW_SET_UNMAPPED:
                    set_register(ADDR_UNMAPPED, script[i].value);
                default:
                    ;
            endcase
        end
        push_sample(-20000, 15000, 1'b0, '0);

        // one full group at the largest count, then single-sample groups
        set_register(ADDR_SAMPLE_COUNT, 8'd255);
        repeat (255) push_sample(pick_axis(), pick_axis(), 1'b0, '0);
        set_register(ADDR_SAMPLE_COUNT, 8'd1);
        repeat (80) push_sample(pick_axis(), pick_axis(), 1'b0, '0);

        while (n_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       cnt = '0;
                1:       cnt = CNT_W'($urandom_range(20, 60));
                default: cnt = CNT_W'($urandom_range(1, 12));
            endcase
            group_len = (cnt == 0) ? 1 : cnt;
            phase_len = group_len * $urandom_range(1, 6) + $urandom_range(0, 3);
            set_register(ADDR_SAMPLE_COUNT, cnt);
            repeat (phase_len) push_sample(pick_axis(), pick_axis(), 1'b0, '0);
        end

        rest_input();
        while (heading_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d samples sent across %0d register writes", n_sent, n_settings);
        $display("%0d mean headings checked, %0d errors", n_checked, n_errors);
        if (n_errors == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/cha_pkg.sv
rtl/cha_queue.sv
rtl/cha_cordic.sv
rtl/cha_accum.sv
rtl/compass_heading_averager_core.sv
tb/sv/tb_top.sv
